@@ design/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy frame allocator package
// Shared constants, result codes and the types that pass between the
// controller, the frame store and the top level.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned MAX_ORDER_DEF        = 10;
  localparam int unsigned FRAME_BYTES_LOG2_DEF = 12;

  // Fixed field widths of the request and response items.
  localparam int unsigned SIZE_W  = 23;
  localparam int unsigned FRAME_W = 10;
  localparam int unsigned ORDER_W = 4;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NOMEM  = 2'd1,
    STS_FREED  = 2'd2,
    STS_NOHEAD = 2'd3
  } status_e;

  // Per-frame state codes kept in the frame store.
  localparam logic [1:0] FS_FREE     = 2'd0;
  localparam logic [1:0] FS_ALLOC    = 2'd1;
  localparam logic [1:0] FS_INTERIOR = 2'd2;

  typedef struct packed {
    logic st_we;
    logic lk_we;
    logic hd_we;
    logic tl_we;
  } bfa_we_t;

  typedef struct packed {
    status_e              status;
    logic [FRAME_W-1:0]   frame;
    logic [ORDER_W-1:0]   order;
  } bfa_res_t;

endpackage

@@ design/bfa_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one allocate or free request per item.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  import bfa_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [SIZE_W-1:0]   size_bytes;
  logic [FRAME_W-1:0]  free_frame;

  modport source (output valid, func, size_bytes, free_frame, input ready);
  modport sink   (input valid, func, size_bytes, free_frame, output ready);
endinterface

@@ design/bfa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item per request.
// ----------------------------------------------------------------------------
interface bfa_rsp_if;
  import bfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [FRAME_W-1:0]  block_frame;
  logic [ORDER_W-1:0]  block_order;

  modport source (output valid, status, block_frame, block_order, input ready);
  modport sink   (input valid, status, block_frame, block_order, output ready);
endinterface

@@ design/bfa_store.sv @@
// ----------------------------------------------------------------------------
// Buddy allocator frame store
// Per-frame state/order memory, free-list link memory and the list head
// and tail registers. One shared registered read port.
// ----------------------------------------------------------------------------
module bfa_store #(
  parameter int unsigned MAX_ORDER = bfa_pkg::MAX_ORDER_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bfa_pkg::bfa_we_t                  we_i,
  input  logic [MAX_ORDER-1:0]              rd_addr_i,
  input  logic [MAX_ORDER-1:0]              st_addr_i,
  input  logic [1:0]                        st_state_i,
  input  logic [$clog2(MAX_ORDER+2)-1:0]    st_order_i,
  input  logic [MAX_ORDER-1:0]              lk_addr_i,
  input  logic [MAX_ORDER:0]                lk_data_i,
  input  logic [$clog2(MAX_ORDER+1)-1:0]    ls_idx_i,
  input  logic [MAX_ORDER:0]                hd_data_i,
  input  logic [MAX_ORDER:0]                tl_data_i,
  output logic [1:0]                        st_state_o,
  output logic [$clog2(MAX_ORDER+2)-1:0]    st_order_o,
  output logic [MAX_ORDER:0]                lk_data_o,
  output logic [MAX_ORDER:0]                hd_o,
  output logic [MAX_ORDER:0]                tl_o
);
  import bfa_pkg::*;

  localparam int unsigned FRAMES = 1 << MAX_ORDER;
  localparam int unsigned OW     = $clog2(MAX_ORDER + 2);
  localparam int unsigned NW     = MAX_ORDER + 1;
  localparam logic [NW-1:0] NIL  = {1'b1, {MAX_ORDER{1'b0}}};

  logic [OW+1:0]  fs_mem [FRAMES];
  logic [NW-1:0]  lk_mem [FRAMES];
  logic [OW+1:0]  fs_rd_q;
  logic [NW-1:0]  lk_rd_q;
  logic [NW-1:0]  head_q [MAX_ORDER+1];
  logic [NW-1:0]  tail_q [MAX_ORDER+1];

  always_ff @(posedge clk_i) begin
    if (we_i.st_we) begin
      fs_mem[st_addr_i] <= {st_state_i, st_order_i};
    end
    if (we_i.lk_we) begin
      lk_mem[lk_addr_i] <= lk_data_i;
    end
    fs_rd_q <= fs_mem[rd_addr_i];
    lk_rd_q <= lk_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head_q[i] <= (i == MAX_ORDER) ? NW'(0) : NIL;
        tail_q[i] <= (i == MAX_ORDER) ? NW'(0) : NIL;
      end
    end else begin
      if (we_i.hd_we) begin
        head_q[ls_idx_i] <= hd_data_i;
      end
      if (we_i.tl_we) begin
        tail_q[ls_idx_i] <= tl_data_i;
      end
    end
  end

  assign st_state_o = fs_rd_q[OW+1:OW];
  assign st_order_o = fs_rd_q[OW-1:0];
  assign lk_data_o  = lk_rd_q;
  assign hd_o       = head_q[ls_idx_i];
  assign tl_o       = tail_q[ls_idx_i];

endmodule

@@ design/bfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Buddy allocator controller
// State machine that sequences the store clearing sweep, size search, list
// scans, splits, merges and list unlinking over the frame store.
// ----------------------------------------------------------------------------
module bfa_ctrl #(
  parameter int unsigned MAX_ORDER        = bfa_pkg::MAX_ORDER_DEF,
  parameter int unsigned FRAME_BYTES_LOG2 = bfa_pkg::FRAME_BYTES_LOG2_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  logic                              req_func_i,
  input  logic [bfa_pkg::SIZE_W-1:0]        req_size_i,
  input  logic [bfa_pkg::FRAME_W-1:0]       req_frame_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output bfa_pkg::bfa_res_t                 res_o,
  output bfa_pkg::bfa_we_t                  we_o,
  output logic [MAX_ORDER-1:0]              rd_addr_o,
  output logic [MAX_ORDER-1:0]              st_addr_o,
  output logic [1:0]                        st_state_o,
  output logic [$clog2(MAX_ORDER+2)-1:0]    st_order_o,
  output logic [MAX_ORDER-1:0]              lk_addr_o,
  output logic [MAX_ORDER:0]                lk_data_o,
  output logic [$clog2(MAX_ORDER+1)-1:0]    ls_idx_o,
  output logic [MAX_ORDER:0]                hd_data_o,
  output logic [MAX_ORDER:0]                tl_data_o,
  input  logic [1:0]                        st_state_i,
  input  logic [$clog2(MAX_ORDER+2)-1:0]    st_order_i,
  input  logic [MAX_ORDER:0]                lk_data_i,
  input  logic [MAX_ORDER:0]                hd_i,
  input  logic [MAX_ORDER:0]                tl_i
);
  import bfa_pkg::*;

  localparam int unsigned FW    = MAX_ORDER;
  localparam int unsigned NW    = MAX_ORDER + 1;
  localparam int unsigned OW    = $clog2(MAX_ORDER + 2);
  localparam int unsigned LW    = $clog2(MAX_ORDER + 1);
  localparam int unsigned THR_W = SIZE_W + 1;
  localparam logic [NW-1:0] NIL = {1'b1, {FW{1'b0}}};
  localparam logic [OW-1:0] OMAX = OW'(MAX_ORDER);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_A_SIZE, S_A_SCAN, S_A_LRD, S_A_POP, S_A_SPL, S_A_APP,
    S_A_FIN, S_F_RD, S_F_CHK, S_F_BRD, S_F_BCHK, S_R_WALK, S_R_WAIT, S_R_CLR,
    S_F_MRG, S_F_FIN, S_F_APP, S_DONE
  } state_e;

  state_e             state_q;
  logic [FW-1:0]      clr_q;
  logic [SIZE_W-1:0]  size_q;
  logic [THR_W-1:0]   thr_q;
  logic [OW-1:0]      want_q;
  logic [OW-1:0]      ord_q;
  logic [OW-1:0]      j_q;
  logic [FW-1:0]      f_q;
  logic [FW-1:0]      cur_q;
  logic [FW-1:0]      buddy_q;
  logic [NW-1:0]      prev_q;
  logic [NW-1:0]      walk_q;
  bfa_res_t           res_q;

  logic [OW-1:0]      j_m1;
  logic [FW-1:0]      half;
  logic [FW-1:0]      ord_bit;
  logic               req_fire;

  assign j_m1     = j_q - OW'(1);
  assign half     = f_q | (FW'(1) << j_m1);
  assign ord_bit  = FW'(1) << ord_q;
  assign req_fire = req_valid_i && req_ready_o;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // Store commands decoded from the current state.
  always_comb begin
    we_o       = '0;
    rd_addr_o  = cur_q;
    st_addr_o  = cur_q;
    st_state_o = FS_FREE;
    st_order_o = ord_q;
    lk_addr_o  = cur_q;
    lk_data_o  = NIL;
    ls_idx_o   = ord_q[LW-1:0];
    hd_data_o  = NIL;
    tl_data_o  = NIL;
    unique case (state_q)
      S_CLR: begin
        we_o.st_we = 1'b1;
        we_o.lk_we = 1'b1;
        st_addr_o  = clr_q;
        lk_addr_o  = clr_q;
        st_state_o = (clr_q == '0) ? FS_FREE : FS_INTERIOR;
        st_order_o = (clr_q == '0) ? OMAX : '0;
      end
      S_A_LRD: rd_addr_o = f_q;
      S_A_POP: begin
        we_o.hd_we = 1'b1;
        we_o.tl_we = lk_data_i[FW];
        we_o.lk_we = 1'b1;
        hd_data_o  = lk_data_i;
        lk_addr_o  = f_q;
      end
      S_A_SPL: begin
        we_o.st_we = (j_q > want_q);
        we_o.lk_we = (j_q > want_q);
        st_addr_o  = half;
        st_order_o = j_m1;
        lk_addr_o  = half;
      end
      S_A_APP: begin
        ls_idx_o   = j_m1[LW-1:0];
        we_o.hd_we = hd_i[FW];
        we_o.tl_we = 1'b1;
        we_o.lk_we = !hd_i[FW] && !tl_i[FW];
        hd_data_o  = {1'b0, half};
        tl_data_o  = {1'b0, half};
        lk_addr_o  = tl_i[FW-1:0];
        lk_data_o  = {1'b0, half};
      end
      S_A_FIN: begin
        we_o.st_we = 1'b1;
        st_addr_o  = f_q;
        st_state_o = FS_ALLOC;
        st_order_o = want_q;
      end
      S_F_BRD: rd_addr_o = cur_q ^ ord_bit;
      S_R_WALK: rd_addr_o = walk_q[FW-1:0];
      S_R_WAIT: begin
        if (walk_q[FW-1:0] == buddy_q) begin
          we_o.hd_we = prev_q[FW];
          we_o.lk_we = !prev_q[FW];
          we_o.tl_we = (tl_i == {1'b0, buddy_q});
          hd_data_o  = lk_data_i;
          lk_addr_o  = prev_q[FW-1:0];
          lk_data_o  = lk_data_i;
          tl_data_o  = prev_q;
        end
      end
      S_R_CLR: begin
        we_o.lk_we = 1'b1;
        lk_addr_o  = buddy_q;
      end
      S_F_MRG: begin
        we_o.st_we = 1'b1;
        we_o.lk_we = 1'b1;
        st_addr_o  = cur_q | ord_bit;
        st_state_o = FS_INTERIOR;
        st_order_o = '0;
        lk_addr_o  = cur_q | ord_bit;
      end
      S_F_FIN: begin
        we_o.st_we = 1'b1;
        we_o.lk_we = 1'b1;
      end
      S_F_APP: begin
        we_o.hd_we = hd_i[FW];
        we_o.tl_we = 1'b1;
        we_o.lk_we = !hd_i[FW] && !tl_i[FW];
        hd_data_o  = {1'b0, cur_q};
        tl_data_o  = {1'b0, cur_q};
        lk_addr_o  = tl_i[FW-1:0];
        lk_data_o  = {1'b0, cur_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      size_q  <= '0;
      thr_q   <= '0;
      want_q  <= '0;
      ord_q   <= '0;
      j_q     <= '0;
      f_q     <= '0;
      cur_q   <= '0;
      buddy_q <= '0;
      prev_q  <= NIL;
      walk_q  <= NIL;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + FW'(1);
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            if (!req_func_i) begin
              size_q  <= req_size_i;
              want_q  <= '0;
              thr_q   <= THR_W'(1) << FRAME_BYTES_LOG2;
              state_q <= S_A_SIZE;
            end else begin
              cur_q   <= FW'(req_frame_i);
              state_q <= S_F_RD;
            end
          end
        end
        S_A_SIZE: begin
          if (want_q > OMAX) begin
            res_q   <= '{status: STS_NOMEM, frame: '0, order: '0};
            state_q <= S_DONE;
          end else if (thr_q >= {1'b0, size_q}) begin
            ord_q   <= want_q;
            state_q <= S_A_SCAN;
          end else begin
            want_q <= want_q + OW'(1);
            thr_q  <= thr_q << 1;
          end
        end
        S_A_SCAN: begin
          if (ord_q > OMAX) begin
            res_q   <= '{status: STS_NOMEM, frame: '0, order: '0};
            state_q <= S_DONE;
          end else if (hd_i[FW]) begin
            ord_q <= ord_q + OW'(1);
          end else begin
            f_q     <= hd_i[FW-1:0];
            state_q <= S_A_LRD;
          end
        end
        S_A_LRD: state_q <= S_A_POP;
        S_A_POP: begin
          j_q     <= ord_q;
          state_q <= S_A_SPL;
        end
        S_A_SPL: state_q <= (j_q > want_q) ? S_A_APP : S_A_FIN;
        S_A_APP: begin
          j_q     <= j_m1;
          state_q <= S_A_SPL;
        end
        S_A_FIN: begin
          res_q   <= '{status: STS_OK, frame: FRAME_W'(f_q), order: ORDER_W'(want_q)};
          state_q <= S_DONE;
        end
        S_F_RD: state_q <= S_F_CHK;
        S_F_CHK: begin
          if (st_state_i == FS_FREE) begin
            res_q   <= '{status: STS_FREED, frame: '0, order: '0};
            state_q <= S_DONE;
          end else if (st_state_i != FS_ALLOC) begin
            res_q   <= '{status: STS_NOHEAD, frame: '0, order: '0};
            state_q <= S_DONE;
          end else begin
            ord_q   <= (st_order_i > OMAX) ? OMAX : st_order_i;
            state_q <= S_F_BRD;
          end
        end
        S_F_BRD: begin
          if (ord_q >= OMAX) begin
            state_q <= S_F_FIN;
          end else begin
            buddy_q <= cur_q ^ ord_bit;
            state_q <= S_F_BCHK;
          end
        end
        S_F_BCHK: begin
          if (st_state_i == FS_FREE && st_order_i == ord_q) begin
            prev_q  <= NIL;
            walk_q  <= hd_i;
            state_q <= S_R_WALK;
          end else begin
            state_q <= S_F_FIN;
          end
        end
        S_R_WALK: state_q <= walk_q[FW] ? S_F_MRG : S_R_WAIT;
        S_R_WAIT: begin
          if (walk_q[FW-1:0] == buddy_q) begin
            state_q <= S_R_CLR;
          end else begin
            prev_q  <= walk_q;
            walk_q  <= lk_data_i;
            state_q <= S_R_WALK;
          end
        end
        S_R_CLR: state_q <= S_F_MRG;
        S_F_MRG: begin
          cur_q   <= cur_q & ~ord_bit;
          ord_q   <= ord_q + OW'(1);
          state_q <= S_F_BRD;
        end
        S_F_FIN: state_q <= S_F_APP;
        S_F_APP: begin
          res_q   <= '{status: STS_OK, frame: FRAME_W'(cur_q), order: ORDER_W'(ord_q)};
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_clr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !req_ready_o)
    else $error("request accepted during store initialization");

  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_o)
    else $error("second request taken while one is in progress");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != STS_OK) |-> (res_o.frame == '0 && res_o.order == '0))
    else $error("error result carries nonzero frame or order");

  a_ok_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == STS_OK) |-> (res_o.order <= ORDER_W'(MAX_ORDER)))
    else $error("result order above the top order");

endmodule

@@ design/buddy_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// Buddy frame allocator
// Allocates and frees power-of-two blocks of page frames with split and
// merge over per-order free lists, one request at a time.
// One request is in flight at a time; the next can be taken in the cycle
// after the result enters the output register. After reset the whole store
// is swept clear; no request is taken until that sweep is done.
// ----------------------------------------------------------------------------
module buddy_frame_allocator #(
  parameter int unsigned MAX_ORDER        = bfa_pkg::MAX_ORDER_DEF,
  parameter int unsigned FRAME_BYTES_LOG2 = bfa_pkg::FRAME_BYTES_LOG2_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bfa_req_if.sink        req_i,
  bfa_rsp_if.source      rsp_o
);
  import bfa_pkg::*;

  localparam int unsigned OW = $clog2(MAX_ORDER + 2);
  localparam int unsigned LW = $clog2(MAX_ORDER + 1);

  // Controller to store command and status wiring.
  bfa_we_t              we;
  logic [MAX_ORDER-1:0] rd_addr;
  logic [MAX_ORDER-1:0] st_addr;
  logic [1:0]           st_state_wr;
  logic [OW-1:0]        st_order_wr;
  logic [MAX_ORDER-1:0] lk_addr;
  logic [MAX_ORDER:0]   lk_data_wr;
  logic [LW-1:0]        ls_idx;
  logic [MAX_ORDER:0]   hd_wr;
  logic [MAX_ORDER:0]   tl_wr;
  logic [1:0]           st_state_rd;
  logic [OW-1:0]        st_order_rd;
  logic [MAX_ORDER:0]   lk_data_rd;
  logic [MAX_ORDER:0]   hd_rd;
  logic [MAX_ORDER:0]   tl_rd;

  // Result hand-off from the controller into the output register.
  logic      res_valid;
  logic      res_ready;
  bfa_res_t  res;
  logic      out_valid_q;
  bfa_res_t  out_q;

  bfa_ctrl #(
    .MAX_ORDER        (MAX_ORDER),
    .FRAME_BYTES_LOG2 (FRAME_BYTES_LOG2)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_func_i  (req_i.func),
    .req_size_i  (req_i.size_bytes),
    .req_frame_i (req_i.free_frame),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .rd_addr_o   (rd_addr),
    .st_addr_o   (st_addr),
    .st_state_o  (st_state_wr),
    .st_order_o  (st_order_wr),
    .lk_addr_o   (lk_addr),
    .lk_data_o   (lk_data_wr),
    .ls_idx_o    (ls_idx),
    .hd_data_o   (hd_wr),
    .tl_data_o   (tl_wr),
    .st_state_i  (st_state_rd),
    .st_order_i  (st_order_rd),
    .lk_data_i   (lk_data_rd),
    .hd_i        (hd_rd),
    .tl_i        (tl_rd)
  );

  bfa_store #(
    .MAX_ORDER (MAX_ORDER)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (we),
    .rd_addr_i  (rd_addr),
    .st_addr_i  (st_addr),
    .st_state_i (st_state_wr),
    .st_order_i (st_order_wr),
    .lk_addr_i  (lk_addr),
    .lk_data_i  (lk_data_wr),
    .ls_idx_i   (ls_idx),
    .hd_data_i  (hd_wr),
    .tl_data_i  (tl_wr),
    .st_state_o (st_state_rd),
    .st_order_o (st_order_rd),
    .lk_data_o  (lk_data_rd),
    .hd_o       (hd_rd),
    .tl_o       (tl_rd)
  );

  // The output register takes a new result whenever it is empty or its
  // current item is being taken in the same cycle.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.block_frame = out_q.frame;
  assign rsp_o.block_order = out_q.order;

endmodule

@@ tb/bfa_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator scoreboard
// Keeps a cycle-free model of the frame store and free lists, predicts one
// result per accepted request and compares it with the block's output.
// ----------------------------------------------------------------------------
package bfa_tb_pkg;
  import bfa_pkg::*;

  localparam int unsigned NORD   = MAX_ORDER_DEF;
  localparam int unsigned NFRAME = 1 << NORD;
  localparam int unsigned NIL    = NFRAME;

  typedef struct packed {
    status_e            status;
    logic [FRAME_W-1:0] frame;
    logic [ORDER_W-1:0] order;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [1:0]    fstate [NFRAME];
    int unsigned   forder [NFRAME];
    int unsigned   link   [NFRAME];
    int unsigned   lhead  [NORD+1];
    int unsigned   ltail  [NORD+1];
    alloc_result_t pending[$];
    int unsigned   errors;
    int unsigned   live_heads[$];

    function new();
      errors = 0;
      for (int i = 0; i < NFRAME; i++) begin
        fstate[i] = FS_INTERIOR;
        forder[i] = 0;
        link[i]   = NIL;
      end
      for (int i = 0; i <= NORD; i++) begin
        lhead[i] = NIL;
        ltail[i] = NIL;
      end
      fstate[0]   = FS_FREE;
      forder[0]   = NORD;
      lhead[NORD] = 0;
      ltail[NORD] = 0;
    endfunction

    function void append(int unsigned o, int unsigned x);
      link[x] = NIL;
      if (lhead[o] >= NFRAME) lhead[o] = x;
      else if (ltail[o] < NFRAME) link[ltail[o]] = x;
      ltail[o] = x;
    endfunction

    function void unlink(int unsigned o, int unsigned x);
      int unsigned prev;
      int unsigned cur;
      prev = NIL;
      cur  = lhead[o];
      for (int s = 0; s < NFRAME && cur < NFRAME; s++) begin
        if (cur == x) begin
          if (prev >= NFRAME) lhead[o] = link[cur];
          else link[prev] = link[cur];
          if (ltail[o] == x) ltail[o] = prev;
          link[x] = NIL;
          return;
        end
        prev = cur;
        cur  = link[cur];
      end
    endfunction

    function alloc_result_t allocate(logic [SIZE_W-1:0] sz);
      alloc_result_t r;
      int unsigned want;
      int unsigned f;
      r = '{STS_NOMEM, '0, '0};
      want = 0;
      while (want <= NORD && (64'd1 << (FRAME_BYTES_LOG2_DEF + want)) < sz) want++;
      for (int unsigned o = want; o <= NORD; o++) begin
        f = lhead[o];
        if (f >= NFRAME) continue;
        lhead[o] = link[f];
        if (lhead[o] >= NFRAME) ltail[o] = NIL;
        link[f] = NIL;
        for (int unsigned j = o; j > want; j--) begin
          fstate[f + (1 << (j-1))] = FS_FREE;
          forder[f + (1 << (j-1))] = j - 1;
          append(j - 1, f + (1 << (j-1)));
        end
        fstate[f] = FS_ALLOC;
        forder[f] = want;
        live_heads.push_back(f);
        r = '{STS_OK, f[FRAME_W-1:0], want[ORDER_W-1:0]};
        return r;
      end
      return r;
    endfunction

    function alloc_result_t release_block(logic [FRAME_W-1:0] idx);
      int unsigned cur;
      int unsigned o;
      int unsigned bud;
      cur = idx;
      if (fstate[cur] == FS_FREE) return '{STS_FREED, '0, '0};
      if (fstate[cur] != FS_ALLOC) return '{STS_NOHEAD, '0, '0};
      o = forder[cur];
      if (o > NORD) o = NORD;
      while (o < NORD) begin
        bud = cur ^ (1 << o);
        if (fstate[bud] != FS_FREE || forder[bud] != o) break;
        unlink(o, bud);
        if (bud > cur) begin
          fstate[bud] = FS_INTERIOR; forder[bud] = 0; link[bud] = NIL;
        end else begin
          fstate[cur] = FS_INTERIOR; forder[cur] = 0; link[cur] = NIL;
          cur = bud;
        end
        o++;
      end
      fstate[cur] = FS_FREE;
      forder[cur] = o;
      append(o, cur);
      return '{STS_OK, cur[FRAME_W-1:0], o[ORDER_W-1:0]};
    endfunction

    // Notes one accepted request and queues its predicted result.
    function void note_request(logic fn, logic [SIZE_W-1:0] sz, logic [FRAME_W-1:0] idx);
      if (fn == 1'b0) pending.push_back(allocate(sz));
      else pending.push_back(release_block(idx));
    endfunction

    function void check_result(logic [1:0] st, logic [FRAME_W-1:0] fr, logic [ORDER_W-1:0] od);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result st=%0d frame=%0d order=%0d", $time, st, fr, od);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status || fr !== e.frame || od !== e.order) begin
        $display("%0t: mismatch expected st=%0d frame=%0d order=%0d, actual st=%0d frame=%0d order=%0d",
                 $time, e.status, e.frame, e.order, st, fr, od);
        errors++;
      end
    endfunction
  endclass
endpackage

@@ tb/buddy_frame_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy frame allocator test
// Drives directed and random allocate and free requests through the request
// channel under varying idle and stall pressure, and checks every response
// against a scoreboard that tracks the free lists.
// ----------------------------------------------------------------------------
module buddy_frame_allocator_test;
  import bfa_pkg::*;
  import bfa_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  bfa_req_if req_if ();
  bfa_rsp_if rsp_if ();

  buddy_frame_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  alloc_scoreboard board = new();
  // Percent of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit sending_done = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.func = 1'b0;
    req_if.size_bytes = '0;
    req_if.free_frame = '0;
    rsp_if.ready = 1'b0;
  end

  // Every handshake is sampled at the edge; the model is updated there too.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      board.note_request(req_if.func, req_if.size_bytes, req_if.free_frame);
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      board.check_result(rsp_if.status, rsp_if.block_frame, rsp_if.block_order);
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one request, idling beforehand as the current phase asks, and
  // holds it until accepted. Valid stays high afterwards so that a request
  // that follows at once replaces it in the same cycle.
  task automatic send_request(logic fn, logic [SIZE_W-1:0] sz, logic [FRAME_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= fn;
    req_if.size_bytes <= sz;
    req_if.free_frame <= idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Picks a size for the given order: anywhere in (2^(o-1), 2^o] pages, or up to one page for order 0.
  function automatic logic [SIZE_W-1:0] size_for(int unsigned o);
    int unsigned hi;
    hi = 1 << (FRAME_BYTES_LOG2_DEF + o);
    if (o == 0) return SIZE_W'($urandom_range(hi));
    return SIZE_W'($urandom_range(hi, hi / 2 + 1));
  endfunction

  // Random traffic: mostly frees of live blocks and small allocations, with
  // some wild frees and oversized or random sizes as noise.
  task automatic random_phase(int unsigned count);
    int unsigned k;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45 && board.live_heads.size() > 0) begin
        k = $urandom_range(board.live_heads.size() - 1);
        send_request(1'b1, SIZE_W'($urandom), FRAME_W'(board.live_heads[k]));
        board.live_heads.delete(k);
      end else if (pick < 55) begin
        send_request(1'b1, SIZE_W'($urandom), FRAME_W'($urandom));
      end else if (pick < 60) begin
        send_request(1'b0, SIZE_W'($urandom), FRAME_W'($urandom));
      end else begin
        send_request(1'b0, size_for($urandom_range(3) == 0 ?
                     $urandom_range(NORD) : $urandom_range(3)), FRAME_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full-store allocation, exhaustion, frees of odd frames,
    // double free, size zero and the largest size, then merge back.
    send_request(1'b0, 23'd4194304, 10'd0);
    send_request(1'b0, 23'd0, 10'd0);
    send_request(1'b0, 23'd4194305, 10'd0);
    send_request(1'b0, '1, 10'd0);
    send_request(1'b1, 23'd0, 10'd1);
    send_request(1'b1, 23'd0, 10'd0);
    send_request(1'b1, '1, 10'd0);
    send_request(1'b0, 23'd0, 10'd0);
    send_request(1'b0, 23'd1, 10'd0);
    send_request(1'b0, 23'd4097, '1);
    send_request(1'b0, 23'd4096, 10'd0);
    send_request(1'b1, 23'd0, 10'd1);
    send_request(1'b1, 23'd0, 10'd2);
    send_request(1'b1, 23'd0, 10'd1023);
    send_request(1'b1, 23'd0, 10'd0);
    send_request(1'b1, 23'd0, 10'd4);
    send_request(1'b1, 23'd0, 10'd0);
    send_request(1'b0, 23'd2097152, 10'd0);
    send_request(1'b0, 23'd2097153, 10'd0);
    send_request(1'b1, 23'd0, 10'd512);
    send_request(1'b1, 23'd0, 10'd0);
    board.live_heads.delete();

    // Random phases under different pressure, including an idle-free one.
    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(400);
    send_idle_pct = 54; recv_stall_pct = 0;  random_phase(350);
    send_idle_pct = 0;  recv_stall_pct = 54; random_phase(350);
    send_idle_pct = 30; recv_stall_pct = 30; random_phase(400);
    req_if.valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #40000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ buddy_frame_allocator.f @@
design/bfa_pkg.sv
design/bfa_req_if.sv
design/bfa_rsp_if.sv
design/bfa_store.sv
design/bfa_ctrl.sv
design/buddy_frame_allocator.sv
tb/bfa_tb_pkg.sv
tb/buddy_frame_allocator_test.sv
